### rtl/mirm_pkg.sv
`default_nettype none

package mirm_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] modulus;
    logic        clear;
    logic [63:0] initial_bound;
  } in_item_t;

  typedef struct packed {
    logic [31:0] divisor;
    logic [31:0] inverse;
    logic [63:0] candidate;
    logic        skipped;
    logic [63:0] best;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_DIV,
    ST_FIX,
    ST_KSEL,
    ST_MUL,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath; at most one is high per cycle.
  typedef struct packed {
    logic load;
    logic step_init;
    logic align;
    logic sub;
    logic div_init;
    logic div_step;
    logic fix;
    logic ksel;
    logic mul;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic r1_zero;
    logic align_more;
    logic sub_last;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/mirm_ctrl.sv
`default_nettype none

module mirm_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  mirm_pkg::dp_status_t status,
  output mirm_pkg::dp_cmd_t    cmd
);

  mirm_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mirm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      mirm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mirm_pkg::ST_START;
        end
      end
      mirm_pkg::ST_START: begin
        state_nxt = status.skip ? mirm_pkg::ST_DONE : mirm_pkg::ST_CHECK;
      end
      mirm_pkg::ST_CHECK: begin
        if (status.r1_zero) begin
          cmd.div_init = 1'b1;
          state_nxt    = mirm_pkg::ST_DIV;
        end else begin
          cmd.step_init = 1'b1;
          state_nxt     = mirm_pkg::ST_ALIGN;
        end
      end
      mirm_pkg::ST_ALIGN: begin
        if (status.align_more) begin
          cmd.align = 1'b1;
        end else begin
          state_nxt = mirm_pkg::ST_SUB;
        end
      end
      mirm_pkg::ST_SUB: begin
        cmd.sub = 1'b1;
        if (status.sub_last) begin
          state_nxt = mirm_pkg::ST_CHECK;
        end
      end
      mirm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = mirm_pkg::ST_FIX;
        end
      end
      mirm_pkg::ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = mirm_pkg::ST_KSEL;
      end
      mirm_pkg::ST_KSEL: begin
        cmd.ksel  = 1'b1;
        state_nxt = mirm_pkg::ST_MUL;
      end
      mirm_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mirm_pkg::ST_DONE;
      end
      mirm_pkg::ST_DONE: begin
        // The result register must be empty or emptying in this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = mirm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mirm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.commit | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;
  assign in_ready      = (state_r == mirm_pkg::ST_IDLE);

endmodule

`default_nettype wire

### rtl/mirm_dp.sv
`default_nettype none

module mirm_dp #(
  parameter int unsigned OPERAND_WIDTH = mirm_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mirm_pkg::in_item_t   in_data,
  input  mirm_pkg::dp_cmd_t    cmd,
  output mirm_pkg::dp_status_t status,
  output mirm_pkg::out_item_t  out_data
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned SW = W + 3;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]          a_r, m_r;
  logic [W-1:0]          r0_r, r1_r, d_r;
  logic signed [SW-1:0]  s0_r, s1_r, ds_r;
  logic [CW-1:0]         cnt_r;
  logic [W-1:0]          rem_r, quo_r, k_r;
  logic                  neg_r;
  logic                  skip_r;
  logic [2*W-1:0]        prod_r;
  logic [63:0]           min_r;
  mirm_pkg::out_item_t   out_r;

  logic [W:0]            d_dbl;
  logic                  sub_ge;
  logic [W-1:0]          r0_sub;
  logic signed [SW-1:0]  s0_sub;
  logic signed [SW-1:0]  s0_abs;
  logic [W:0]            div_trial;
  logic                  div_ge;
  logic [W:0]            div_diff;
  logic [W-1:0]          a_in, m_in;
  logic [63:0]           cand;
  logic [63:0]           new_min;

  assign a_in = in_data.value[W-1:0];
  assign m_in = in_data.modulus[W-1:0];

  // One Euclid step subtracts aligned copies of r1 from r0 while the same
  // shifts of s1 come off s0, which yields s0 - q*s1 without a multiplier.
  assign d_dbl  = {d_r, 1'b0};
  assign sub_ge = (d_r <= r0_r);
  assign r0_sub = sub_ge ? (r0_r - d_r) : r0_r;
  assign s0_sub = sub_ge ? (s0_r - ds_r) : s0_r;

  assign s0_abs    = s0_r[SW-1] ? -s0_r : s0_r;
  assign div_trial = {rem_r, quo_r[W-1]};
  assign div_ge    = (div_trial >= {1'b0, r0_r});
  assign div_diff  = div_trial - {1'b0, r0_r};

  assign cand    = 64'(prod_r) - 64'd1;
  assign new_min = (cand < min_r) ? cand : min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '1;
    end else if (cmd.load && in_data.clear) begin
      min_r <= in_data.initial_bound;
    end else if (cmd.commit && !skip_r) begin
      min_r <= new_min;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= a_in;
      m_r    <= m_in;
      r0_r   <= a_in;
      r1_r   <= m_in;
      s0_r   <= SW'(1);
      s1_r   <= '0;
      skip_r <= (a_in <= W'(1)) || (m_in <= W'(1));
    end else if (cmd.step_init) begin
      d_r   <= r1_r;
      ds_r  <= s1_r;
      cnt_r <= '0;
    end else if (cmd.align) begin
      d_r   <= d_dbl[W-1:0];
      ds_r  <= ds_r <<< 1;
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.sub) begin
      if (cnt_r == '0) begin
        r0_r <= r1_r;
        r1_r <= r0_sub;
        s0_r <= s1_r;
        s1_r <= s0_sub;
      end else begin
        r0_r  <= r0_sub;
        s0_r  <= s0_sub;
        d_r   <= d_r >> 1;
        ds_r  <= ds_r >>> 1;
        cnt_r <= cnt_r - CW'(1);
      end
    end else if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= s0_abs[W-1:0];
      neg_r <= s0_r[SW-1];
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
      quo_r <= {quo_r[W-2:0], div_ge};
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.fix) begin
      // The quotient magnitude never exceeds the modulus, so one subtract reduces it.
      quo_r <= (quo_r >= m_r) ? (quo_r - m_r) : quo_r;
    end else if (cmd.ksel) begin
      k_r <= (neg_r && (quo_r != '0)) ? (m_r - quo_r) : quo_r;
    end else if (cmd.mul) begin
      prod_r <= k_r * a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (skip_r) begin
        out_r.divisor   <= '0;
        out_r.inverse   <= '0;
        out_r.candidate <= '0;
        out_r.skipped   <= 1'b1;
        out_r.best      <= min_r;
      end else begin
        out_r.divisor   <= 32'(r0_r);
        out_r.inverse   <= 32'(k_r);
        out_r.candidate <= cand;
        out_r.skipped   <= 1'b0;
        out_r.best      <= new_min;
      end
    end
  end

  assign status.skip       = skip_r;
  assign status.r1_zero    = (r1_r == '0);
  assign status.align_more = (d_dbl <= {1'b0, r0_r});
  assign status.sub_last   = (cnt_r == '0);
  assign status.div_last   = (cnt_r == CW'(W - 1));
  assign out_data          = out_r;

endmodule

`default_nettype wire

### rtl/modular_inverse_running_min_core.sv
// Modular inverse with a running minimum. Each transfer brings a value and a
// modulus (low OPERAND_WIDTH bits used); pairs where either is at most one are
// reported as skipped. Otherwise an iterative extended Euclid finds the gcd and
// the coefficient of the value, the coefficient is divided by the gcd and
// brought into 0..modulus-1, and k*value-1 lowers a 64-bit running minimum that
// resets to all ones and reloads from initial_bound when clear is set. One
// pair is in work at a time. The Euclid steps run on a shift-subtract unit
// and the coefficient division on a bit-serial divider. The result register
// lets the next pair enter while a result waits.
`default_nettype none

module modular_inverse_running_min_core #(
  parameter int unsigned OPERAND_WIDTH = mirm_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  mirm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output mirm_pkg::out_item_t out_data
);

  mirm_pkg::dp_cmd_t    cmd;
  mirm_pkg::dp_status_t status;

  mirm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mirm_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### rtl/mirm_checker.sv
`default_nettype none

module mirm_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input mirm_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second pair taken while one is in work");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.skipped |->
      out_data.divisor == '0 && out_data.inverse == '0 && out_data.candidate == '0)
    else $error("skipped pair carries nonzero fields");

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.skipped |->
      out_data.best <= out_data.candidate && out_data.divisor != '0)
    else $error("running minimum above candidate or zero gcd");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind modular_inverse_running_min_core mirm_checker u_chk (.*);

`default_nettype wire
